/* hw/rtl/dmft_pkg.sv */
package dmft_pkg;

    // Fixed field widths
    localparam int unsigned MSG_W     = 16;
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned PLEN_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_LOW_LAST = 2'd2;

    // Configuration reset values
    localparam logic              RST_ENABLED           = 1'b1;
    localparam logic [PLEN_W-1:0] RST_PREAMBLE_LENGTH   = 4'd4;
    localparam logic              RST_PREAMBLE_LOW_LAST = 1'b1;

    typedef struct packed {
        logic              enabled;
        logic [PLEN_W-1:0] preamble_length;
        logic              preamble_low_last;
    } t_cfg;

    typedef struct packed {
        logic line_driven;
        logic line_level;
        logic transmitting;
    } t_result;

endpackage

/* hw/rtl/diff_manchester_frame_transmitter.sv */
// Each result is registered in the output buffer and shown on o_valid from its front entry.
// Throughput: one request per cycle while o_stall is low; the frame state register updates once per accepted request.
// A two-entry output buffer keeps accepting while one result waits; o_stall rises
// only when both entries are full.
// Reset (i_rst_n low, synchronous): frame idle, line low, held word zero,
// registers back to enabled, preamble length 4, low-last set.
module diff_manchester_frame_transmitter
    import dmft_pkg::*;
#(
    parameter int unsigned MSG_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_action,
    input  logic [MSG_W-1:0]     i_message,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_line_driven,
    output logic                 o_line_level,
    output logic                 o_transmitting,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result c_result;
    t_result c_out;
    logic    c_accept;
    logic    c_full;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = c_full;
    assign c_accept    = i_valid && !c_full;

    // configuration registers; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled           <= RST_ENABLED;
            r_cfg.preamble_length   <= RST_PREAMBLE_LENGTH;
            r_cfg.preamble_low_last <= RST_PREAMBLE_LOW_LAST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLED:           r_cfg.enabled           <= i_cfg_data[0];
                CFG_PREAMBLE_LENGTH:   r_cfg.preamble_length   <= i_cfg_data;
                CFG_PREAMBLE_LOW_LAST: r_cfg.preamble_low_last <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dmft_encoder #(
        .MSG_BITS (MSG_BITS)
    ) u_encoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (c_accept),
        .i_action  (i_action),
        .i_message (i_message),
        .i_cfg     (r_cfg),
        .o_result  (c_result)
    );

    dmft_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_accept),
        .i_data  (c_result),
        .o_full  (c_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (c_out)
    );

    assign o_line_driven  = c_out.line_driven;
    assign o_line_level   = c_out.line_level;
    assign o_transmitting = c_out.transmitting;

    // a full buffer always has its front entry on show
    a_full_has_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("output buffer full without a front entry");

    // an accepted request always leaves a result pending
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request produced no result");

    // a high level is only ever shown on a driven tick
    a_level_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_level) |-> o_line_driven)
        else $error("line level high on an undriven step");

endmodule

/* hw/rtl/dmft_encoder.sv */
module dmft_encoder
    import dmft_pkg::*;
#(
    parameter int unsigned MSG_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_action,
    input  logic [MSG_W-1:0] i_message,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    localparam logic [IDX_W-1:0] FRAME_END = IDX_W'(2 * MSG_BITS);
    localparam logic [4:0]       TOP_POS   = 5'(MSG_BITS - 1);

    logic             r_busy, n_busy;
    logic             r_data, n_data;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic             r_level, n_level;
    logic [MSG_W-1:0] r_held, n_held;

    logic             c_data;
    logic [IDX_W-1:0] c_idx;
    logic [IDX_W-1:0] c_idx_inc;
    logic             c_lvl;
    logic [4:0]       c_shift;
    logic [31:0]      c_word;
    logic             c_bit;
    logic             c_driven;
    logic             c_out_level;

    // held word padded to 32 positions; positions 16 and up send as 0
    assign c_word  = {{(32 - MSG_W){1'b0}}, r_held};

    // next state and result for one request
    always_comb begin
        n_busy      = r_busy;
        n_data      = r_data;
        n_idx       = r_idx;
        n_level     = r_level;
        n_held      = r_held;
        c_driven    = 1'b0;
        c_out_level = 1'b0;
        c_data      = r_data;
        c_idx       = r_idx;
        c_lvl       = r_level;
        c_shift     = TOP_POS - c_idx[5:1];
        c_bit       = c_word[c_shift];
        c_idx_inc   = c_idx + 1'b1;

        if (i_action) begin
            n_held = i_message;
            n_busy = 1'b1;
        end else if (i_cfg.enabled) begin
            c_driven = 1'b1;
            if (r_busy) begin
                // preamble done: enter data phase
                if (!r_data && (r_idx >= IDX_W'(i_cfg.preamble_length))) begin
                    c_data = 1'b1;
                    c_lvl  = 1'b0;
                    c_idx  = '0;
                end
                c_shift   = TOP_POS - c_idx[5:1];
                c_bit     = c_word[c_shift];
                c_idx_inc = c_idx + 1'b1;
                if (!c_data) begin
                    c_lvl = 1'b1;
                    if (i_cfg.preamble_low_last &&
                        ({1'b0, c_idx} + 8'd1 >= 8'(i_cfg.preamble_length))) begin
                        c_lvl = 1'b0;
                    end
                end else if (!c_idx[0]) begin
                    // first half: toggle on a zero bit
                    c_lvl = c_lvl ^ ~c_bit;
                end else begin
                    // mid-bit: always toggle
                    c_lvl = ~c_lvl;
                end
                n_data  = c_data;
                n_idx   = c_idx_inc;
                n_level = c_lvl;
                // end of frame: line back to low
                if (c_idx_inc >= FRAME_END) begin
                    n_idx   = '0;
                    n_data  = 1'b0;
                    n_level = 1'b0;
                    n_busy  = 1'b0;
                end
                c_out_level = n_level;
            end
        end
    end

    assign o_result.line_driven  = c_driven;
    assign o_result.line_level   = c_out_level;
    assign o_result.transmitting = n_busy;

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_data  <= 1'b0;
            r_idx   <= '0;
            r_level <= 1'b0;
            r_held  <= '0;
        end else if (i_accept) begin
            r_busy  <= n_busy;
            r_data  <= n_data;
            r_idx   <= n_idx;
            r_level <= n_level;
            r_held  <= n_held;
        end
    end

endmodule

/* hw/rtl/dmft_skid.sv */
module dmft_skid
    import dmft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    c_pop;

    assign c_pop   = r_main_v && !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (c_pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (!r_main_v) begin
            r_main_v <= i_push;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (c_pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_data;
            end
        end else if (!r_main_v) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
